>>> rtl/hsm_pkg.sv
// shared types, constants and sine coefficients for the harmonic sine mix generator
`timescale 1ns / 1ps

package hsm_pkg;

  // one fundamental period in samples, a power of two
  localparam int unsigned SAMPLES_PER_PERIOD = 2048;
  localparam int unsigned PHASE_W = $clog2(SAMPLES_PER_PERIOD);

  // field widths
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned TONE_W = 2;
  localparam int unsigned HA_W   = 9;
  localparam int unsigned CODE_W = 10;
  localparam int unsigned WORD_W = 17;

  localparam int unsigned NUM_TONES   = 4;
  localparam int unsigned TONE_CNT_W  = $clog2(NUM_TONES + 1);
  localparam int unsigned CNT_W       = $clog2(NUM_TONES + 1);
  localparam int unsigned MAX_SHIFT   = NUM_TONES - 1;
  localparam int unsigned SHIFT_IDX_W = IDX_W + MAX_SHIFT;

  // Q16 fraction of a quarter period
  localparam int unsigned F_W      = 17;
  localparam int unsigned FRAC_SH  = 18 - PHASE_W;
  localparam logic [F_W-1:0] F_ONE = F_W'(65536);

  // shared multiplier operands and product
  localparam int unsigned A_W = 33;
  localparam int unsigned B_W = 18;
  localparam int unsigned P_W = A_W + B_W;

  localparam int unsigned SINE_W = 16;
  localparam int unsigned MAG_W  = 15;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned X_W    = 14;
  localparam int unsigned Q15_SH = 15;
  localparam int unsigned Q16_SH = 16;

  localparam logic signed [P_W-1:0] TRUNC16_BIAS = P_W'(65535);
  localparam logic signed [A_W-1:0] TRUNC15_BIAS = A_W'(32767);
  localparam logic signed [A_W-1:0] ROUND_HALF   = A_W'(16384);
  localparam logic signed [A_W-1:0] MAG_MAX      = A_W'(32767);

  // odd Taylor coefficients of sin(pi/2 x), Q30
  localparam logic signed [A_W-1:0] SIN_C1 = A_W'(64'sd1686629713);
  localparam logic signed [A_W-1:0] SIN_C3 = A_W'(64'sd693598669);
  localparam logic signed [A_W-1:0] SIN_C5 = A_W'(64'sd85569273);
  localparam logic signed [A_W-1:0] SIN_C7 = A_W'(64'sd5026995);
  localparam logic signed [A_W-1:0] SIN_C9 = A_W'(64'sd172272);

  // floor(x / 3) = (x * 43691) >> 17 for x below 2^16
  localparam logic signed [B_W-1:0] DIV3_RECIP = B_W'(43691);
  localparam int unsigned DIV3_SH = 17;

  localparam int unsigned DAC_SHIFT    = 6;
  localparam int unsigned DAC_BIAS_BIT = 16;

  localparam logic [HA_W-1:0] HA_RESET = HA_W'(511);

  // tone enable store
  localparam int unsigned MASK_DEPTH = 2;

  localparam logic CMD_TOGGLE = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [TONE_W-1:0] tone_select;
    logic [IDX_W-1:0]  sample_index;
  } hsm_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic [WORD_W-1:0] dac_word;
  } hsm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_PICK,
    ST_MUL,
    ST_STEP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    SP_SQ,
    SP_H9,
    SP_H7,
    SP_H5,
    SP_H3,
    SP_FIN,
    SP_NUM,
    SP_DIV3
  } step_e;

endpackage

>>> rtl/harmonic_sine_mix_dac_generator_top.sv
// top level of the harmonic sine mix generator for a dac
`timescale 1ns / 1ps

// Input channel (in_valid_i / in_stall_o) takes one item: a tone toggle or a
// sample request. A toggle flips the enable of harmonic x1, x2, x4 or x8 and
// gives no output; it reads and writes back the enable store.
// A sample request gives one output item on out_valid_o / out_stall_i with the
// averaged enabled sines as a 10-bit code and the packed dac word.
// Each enabled tone takes six Horner products through one shared multiplier,
// each in a multiply state and an update state; with tones enabled one more
// product scales the sum, and with three enabled another divides by three.
// One item is worked on at a time; in_stall_o is high while it is in flight.
// A finished result sits in the output register, so the next item is accepted
// while the receiver stalls; a later result then waits until that slot frees.
// half_amplitude is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, the block does not enforce it. Reset: all tones
// disabled, half_amplitude = 511, no output pending.

module harmonic_sine_mix_dac_generator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hsm_pkg::HA_W-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  hsm_pkg::hsm_in_t          in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output hsm_pkg::hsm_out_t         out_item_o
);

  import hsm_pkg::*;

  localparam int unsigned MASK_AW = $clog2(MASK_DEPTH);

  state_e state_q, state_d;
  step_e  stp_q, stp_d;

  logic [HA_W-1:0]       ha_q;
  logic                  cmd_q, cmd_d;
  logic [TONE_W-1:0]     tsel_q, tsel_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [NUM_TONES-1:0]  mask_q, mask_d;
  logic                  mask_vld_q;
  logic [TONE_CNT_W-1:0] tone_q, tone_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [F_W-1:0]        f_q, f_d;
  logic                  neg_q, neg_d;
  logic signed [A_W-1:0] a_q, a_d;
  logic signed [B_W-1:0] b_q, b_d;
  logic signed [P_W-1:0] prod_q;
  logic [CODE_W-1:0]     code_q, code_d;
  logic                  out_vld_q, out_vld_d;
  hsm_out_t              out_q, out_d;

  logic                  in_acc;
  logic                  out_load;
  logic                  tones_done;
  logic                  ram_we;
  logic [NUM_TONES-1:0]  ram_rdata;
  logic [NUM_TONES-1:0]  mask_cur;

  logic [SHIFT_IDX_W-1:0]  shifted_idx;
  logic [PHASE_W-1:0]      phase;
  logic [F_W-1:0]          f_lin;
  logic [F_W-1:0]          f_v;
  logic signed [A_W-1:0]   tr16;
  logic signed [A_W-1:0]   rnd;
  logic signed [A_W-1:0]   q15;
  logic [MAG_W-1:0]        mag;
  logic signed [SINE_W-1:0] sine_v;
  logic [X_W-1:0]          x_v;

  // signed divide by 65536 truncating toward zero
  function automatic logic signed [A_W-1:0] trunc16(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] adj;
    adj = x[P_W-1] ? x + TRUNC16_BIAS : x;
    return A_W'(adj >>> Q16_SH);
  endfunction

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_vld_q || !out_stall_i);
  assign tones_done = (tone_q == TONE_CNT_W'(NUM_TONES));
  assign mask_cur   = mask_vld_q ? ram_rdata : '0;

  hsm_ram #(
    .WIDTH (NUM_TONES),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (MASK_AW'(0)),
    .wdata_i (mask_cur ^ (NUM_TONES'(1) << tsel_q)),
    .raddr_i (MASK_AW'(0)),
    .rdata_o (ram_rdata)
  );

  // phase of harmonic 2^t and its quarter-wave fraction
  always_comb begin
    shifted_idx = SHIFT_IDX_W'(idx_q) << tone_q[TONE_W-1:0];
    phase       = shifted_idx[PHASE_W-1:0];
    f_lin       = F_W'(phase[PHASE_W-3:0]) << FRAC_SH;
    f_v         = phase[PHASE_W-2] ? (F_ONE - f_lin) : f_lin;
  end

  // final rounding of the polynomial and sign
  always_comb begin
    tr16 = trunc16(prod_q);
    rnd  = tr16 + ROUND_HALF;
    q15  = rnd[A_W-1] ? ((rnd + TRUNC15_BIAS) >>> Q15_SH) : (rnd >>> Q15_SH);
    if (q15[A_W-1]) begin
      mag = '0;
    end else if (q15 > MAG_MAX) begin
      mag = MAG_W'(MAG_MAX);
    end else begin
      mag = q15[MAG_W-1:0];
    end
    sine_v = neg_q ? -$signed(SINE_W'(mag)) : $signed(SINE_W'(mag));
    x_v    = X_W'(prod_q >>> Q15_SH);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_RD;
      end
      ST_RD: begin
        state_d = (cmd_q == CMD_TOGGLE) ? ST_IDLE : ST_PICK;
      end
      ST_PICK: begin
        if (tones_done) begin
          state_d = (cnt_q == '0) ? ST_OUT : ST_MUL;
        end else if (mask_q[tone_q[TONE_W-1:0]]) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        unique case (stp_q)
          SP_FIN:  state_d = ST_PICK;
          SP_NUM:  state_d = (cnt_q == CNT_W'(3)) ? ST_MUL : ST_OUT;
          SP_DIV3: state_d = ST_OUT;
          default: state_d = ST_MUL;
        endcase
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d     = cmd_q;
    tsel_d    = tsel_q;
    idx_d     = idx_q;
    mask_d    = mask_q;
    tone_d    = tone_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    f_d       = f_q;
    neg_d     = neg_q;
    a_d       = a_q;
    b_d       = b_q;
    stp_d     = stp_q;
    code_d    = code_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    ram_we    = 1'b0;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = in_item_i.command;
          tsel_d = in_item_i.tone_select;
          idx_d  = in_item_i.sample_index;
        end
      end
      ST_RD: begin
        if (cmd_q == CMD_TOGGLE) begin
          ram_we = 1'b1;
        end else begin
          mask_d = mask_cur;
          tone_d = '0;
          cnt_d  = '0;
          sum_d  = '0;
        end
      end
      ST_PICK: begin
        if (tones_done) begin
          if (cnt_q == '0) begin
            code_d = CODE_W'(ha_q);
          end else begin
            a_d   = A_W'(sum_q) + $signed(A_W'({cnt_q, {Q15_SH{1'b0}}}));
            b_d   = $signed(B_W'(ha_q));
            stp_d = SP_NUM;
          end
        end else if (mask_q[tone_q[TONE_W-1:0]]) begin
          f_d   = f_v;
          neg_d = phase[PHASE_W-1];
          a_d   = $signed(A_W'(f_v));
          b_d   = $signed(B_W'(f_v));
          stp_d = SP_SQ;
        end else begin
          tone_d = tone_q + TONE_CNT_W'(1);
        end
      end
      ST_MUL: begin
      end
      ST_STEP: begin
        unique case (stp_q)
          SP_SQ: begin
            // f squared in Q16 stays as the horner multiplier
            b_d   = B_W'(prod_q >>> Q16_SH);
            a_d   = SIN_C9;
            stp_d = SP_H9;
          end
          SP_H9: begin
            a_d   = tr16 - SIN_C7;
            stp_d = SP_H7;
          end
          SP_H7: begin
            a_d   = tr16 + SIN_C5;
            stp_d = SP_H5;
          end
          SP_H5: begin
            a_d   = tr16 - SIN_C3;
            stp_d = SP_H3;
          end
          SP_H3: begin
            a_d   = tr16 + SIN_C1;
            b_d   = $signed(B_W'(f_q));
            stp_d = SP_FIN;
          end
          SP_FIN: begin
            sum_d  = sum_q + SUM_W'(sine_v);
            cnt_d  = cnt_q + CNT_W'(1);
            tone_d = tone_q + TONE_CNT_W'(1);
          end
          SP_NUM: begin
            // scaled sum over 32768, then over the tone count
            case (cnt_q)
              CNT_W'(3): begin
                a_d   = $signed(A_W'(x_v));
                b_d   = DIV3_RECIP;
                stp_d = SP_DIV3;
              end
              CNT_W'(2): code_d = CODE_W'(x_v >> 1);
              CNT_W'(4): code_d = CODE_W'(x_v >> 2);
              default:   code_d = CODE_W'(x_v);
            endcase
          end
          SP_DIV3: begin
            code_d = CODE_W'(prod_q >>> DIV3_SH);
          end
          default: begin
          end
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          out_d.dac_code = code_q;
          out_d.dac_word = (WORD_W'(code_q) << DAC_SHIFT) |
                           (WORD_W'(1) << DAC_BIAS_BIT);
          out_vld_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      stp_q      <= SP_SQ;
      ha_q       <= HA_RESET;
      mask_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      tone_q     <= '0;
      cnt_q      <= '0;
    end else begin
      state_q   <= state_d;
      stp_q     <= stp_d;
      out_vld_q <= out_vld_d;
      tone_q    <= tone_d;
      cnt_q     <= cnt_d;
      if (cfg_we_i) ha_q <= cfg_wdata_i;
      if (ram_we) mask_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    tsel_q <= tsel_d;
    idx_q  <= idx_d;
    mask_q <= mask_d;
    sum_q  <= sum_d;
    f_q    <= f_d;
    neg_q  <= neg_d;
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= a_q * b_q;
    code_q <= code_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_word_packs_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.dac_word[DAC_BIAS_BIT] &&
                     out_item_o.dac_word[DAC_SHIFT-1:0] == '0 &&
                     out_item_o.dac_word[DAC_SHIFT+CODE_W-1:DAC_SHIFT] ==
                     out_item_o.dac_code))
    else $error("dac word does not match dac code");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(NUM_TONES)) && (tone_q <= TONE_CNT_W'(NUM_TONES)))
    else $error("tone counters out of range");

  a_toggle_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.command == CMD_TOGGLE) |-> ##2 mask_vld_q)
    else $error("toggle did not reach the enable store");

  a_sample_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && stp_q == SP_DIV3) |=> (state_q == ST_OUT))
    else $error("division result did not go to output stage");
`endif

endmodule

>>> rtl/hsm_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module hsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
